FILE: sv/tie_pkg.sv
// Package: command codes, status codes and queue entry type for the execute unit.
package tie_pkg;

    localparam logic [5:0] CMD_NOP     = 6'd0;
    localparam logic [5:0] CMD_BRNZP   = 6'd7;
    localparam logic [5:0] CMD_ADD     = 6'd8;
    localparam logic [5:0] CMD_MUL     = 6'd9;
    localparam logic [5:0] CMD_SUB     = 6'd10;
    localparam logic [5:0] CMD_DIV     = 6'd11;
    localparam logic [5:0] CMD_ADDI    = 6'd12;
    localparam logic [5:0] CMD_MOD     = 6'd13;
    localparam logic [5:0] CMD_AND     = 6'd14;
    localparam logic [5:0] CMD_NOT     = 6'd15;
    localparam logic [5:0] CMD_OR      = 6'd16;
    localparam logic [5:0] CMD_XOR     = 6'd17;
    localparam logic [5:0] CMD_ANDI    = 6'd18;
    localparam logic [5:0] CMD_LDR     = 6'd19;
    localparam logic [5:0] CMD_STR     = 6'd20;
    localparam logic [5:0] CMD_CONST   = 6'd21;
    localparam logic [5:0] CMD_HICONST = 6'd22;
    localparam logic [5:0] CMD_CMP     = 6'd23;
    localparam logic [5:0] CMD_CMPU    = 6'd24;
    localparam logic [5:0] CMD_CMPI    = 6'd25;
    localparam logic [5:0] CMD_CMPIU   = 6'd26;
    localparam logic [5:0] CMD_SLL     = 6'd27;
    localparam logic [5:0] CMD_SRA     = 6'd28;
    localparam logic [5:0] CMD_SRL     = 6'd29;
    localparam logic [5:0] CMD_JSRR    = 6'd30;
    localparam logic [5:0] CMD_JSR     = 6'd31;
    localparam logic [5:0] CMD_JMPR    = 6'd32;
    localparam logic [5:0] CMD_JMP     = 6'd33;
    localparam logic [5:0] CMD_TRAP    = 6'd34;
    localparam logic [5:0] CMD_RTI     = 6'd35;
    localparam logic [5:0] CMD_ILLEGAL = 6'd36;
    localparam logic [5:0] CMD_LOADW   = 6'd37;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EXIT      = 4'd1;
    localparam logic [3:0] ST_UDATA_PC  = 4'd2;
    localparam logic [3:0] ST_OSDATA_PC = 4'd3;
    localparam logic [3:0] ST_OSCODE_PC = 4'd4;
    localparam logic [3:0] ST_ILLEGAL   = 4'd5;
    localparam logic [3:0] ST_UCODE_D   = 4'd6;
    localparam logic [3:0] ST_OSCODE_D  = 4'd7;
    localparam logic [3:0] ST_OSDATA_D  = 4'd8;

    localparam logic [15:0] PSR_RESET = 16'h8002;
    localparam logic [15:0] EXIT_PC   = 16'h80FF;

    // Classified instruction handed from front to back
    typedef struct packed {
        logic [5:0]  cmd;
        logic        is_loadw;
        logic        is_div;
        logic        is_mem;
        logic        illegal;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg_s;
        logic [2:0]  src_reg_t;
        logic [15:0] imm;
        logic [15:0] load_address;
    } instr_t;

    // Result word
    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] next_pc;
        logic [15:0] psr_value;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
    } result_t;

endpackage

FILE: sv/teaching_isa_execute_unit.sv
// Top level of the execute unit: front queue, back-end sequencer, result register.
//
//  channel | handshake            | words
//  --------+----------------------+------------------------------------------
//  input   | push / full          | cmd, dest_reg, src_reg_s, src_reg_t, imm,
//          |                      | load_address
//  result  | empty / pop          | status, next_pc, psr_value, reg_*, mem_*
//  config  | cfg_valid / cfg_ready| cfg_data (start_pc, also loads the PC)
//
// Each word takes the back-end sequencer through take, read, execute,
// memory/result and turnaround steps, and only then is the next word taken.
// DIV and MOD add a wait on the bit-serial divider after the execute step.
// The front queue holds two words, so pushes continue while the back works.
// Reset clears registers and halt, sets PC (0x8200) and PSR (0x8002), then a pass
// zeroes all 65536 words of data memory before the first word starts.
// A pending result stalls the back only at the memory step, until it is popped.
// cfg_ready is high while the back is idle and the front queue is empty.
module teaching_isa_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  cmd,
    input  logic [2:0]  dest_reg,
    input  logic [2:0]  src_reg_s,
    input  logic [2:0]  src_reg_t,
    input  logic [15:0] imm,
    input  logic [15:0] load_address,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  status,
    output logic [15:0] next_pc,
    output logic [15:0] psr_value,
    output logic        reg_written,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import tie_pkg::*;

    logic    q_valid, q_take, res_valid;
    instr_t  q_word;
    result_t res_word;

    tie_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .dest_reg     (dest_reg),
        .src_reg_s    (src_reg_s),
        .src_reg_t    (src_reg_t),
        .imm          (imm),
        .load_address (load_address),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_word       (q_word)
    );

    tie_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_word    (q_word),
        .res_valid (res_valid),
        .res_take  (pop),
        .res_word  (res_word)
    );

    // Result word onto ports
    assign empty       = !res_valid;
    assign status      = res_word.status;
    assign next_pc     = res_word.next_pc;
    assign psr_value   = res_word.psr_value;
    assign reg_written = res_word.reg_written;
    assign reg_index   = res_word.reg_index;
    assign reg_value   = res_word.reg_value;
    assign mem_written = res_word.mem_written;
    assign mem_address = res_word.mem_address;
    assign mem_value   = res_word.mem_value;

endmodule

FILE: sv/tie_front.sv
// Front end: accepts and classifies instruction words into a short queue.
module tie_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [5:0]     cmd,
    input  logic [2:0]     dest_reg,
    input  logic [2:0]     src_reg_s,
    input  logic [2:0]     src_reg_t,
    input  logic [15:0]    imm,
    input  logic [15:0]    load_address,
    output logic           q_valid,
    input  logic           q_take,
    output tie_pkg::instr_t q_word
);
    import tie_pkg::*;

    instr_t     slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       do_push, do_pop;
    instr_t     cls;

    // Classification
    always_comb
    begin
        cls.cmd          = cmd;
        cls.is_loadw     = (cmd == CMD_LOADW);
        cls.is_div       = (cmd == CMD_DIV) || (cmd == CMD_MOD);
        cls.is_mem       = (cmd == CMD_LDR) || (cmd == CMD_STR);
        cls.illegal      = (cmd >= CMD_ILLEGAL) && (cmd != CMD_LOADW);
        cls.dest_reg     = dest_reg;
        cls.src_reg_s    = src_reg_s;
        cls.src_reg_t    = src_reg_t;
        cls.imm          = imm;
        cls.load_address = load_address;
    end

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign do_pop  = q_take && q_valid;
    assign q_word  = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= cls;
        end
    end

endmodule

FILE: sv/tie_divider.sv
// Unsigned 16-bit restoring divider, one quotient bit per cycle.
module tie_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] q_reg, r_reg, d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [16:0] shifted;

    assign shifted   = {r_reg, q_reg[15]};
    assign trial     = shifted - {1'b0, d_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    // One shift-subtract step per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 16'd0;
            d_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            if (!trial[16])
            begin
                r_reg <= trial[15:0];
                q_reg <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[15:0];
                q_reg <= {q_reg[14:0], 1'b0};
            end
        end
    end

endmodule

FILE: sv/tie_back.sv
// Back end: executes queued instructions against registers, PC, PSR and data memory.
module tie_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data,
    input  logic            q_valid,
    output logic            q_take,
    input  tie_pkg::instr_t q_word,
    output logic            res_valid,
    input  logic            res_take,
    output tie_pkg::result_t res_word
);
    import tie_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, psr_reg;
    logic        halted_reg;
    logic [3:0]  hcode_reg;
    instr_t      ins_reg;
    logic [15:0] rs_reg, rt_reg, rd_reg, r7_reg;
    logic [15:0] mem [65536];
    logic [15:0] mrd_reg;
    logic [15:0] mem_wdata;
    logic [15:0] mem_waddr;
    logic        mem_we;
    logic [15:0] mem_raddr;
    logic        mem_re;
    result_t     res_reg, res_next;
    logic        res_valid_reg;
    logic [31:0] prod_reg;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_q, div_r;
    logic        clr_busy_reg;
    logic [15:0] clr_addr_reg;
    logic        mem_go, exec_ok, exec_fault;

    // Execute-stage combinational values
    logic [15:0] pc1, addr, val, npc, psr_n;
    logic        wreg, setcc, fromcmp;
    logic [2:0]  widx, ccv;
    logic [3:0]  st, amt;
    logic [15:0] sra_val;

    assign q_take    = (state_reg == S_IDLE) && q_valid && !clr_busy_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !q_valid;
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    // Memory step completes once the result register is free
    assign mem_go     = (state_reg == S_MEM) && (!res_valid_reg || res_take);
    assign exec_ok    = mem_go && !ins_reg.is_loadw && !halted_reg && (st == ST_OK);
    assign exec_fault = mem_go && !ins_reg.is_loadw && !halted_reg && (st != ST_OK);

    tie_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rs_reg),
        .divisor   (rt_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    function automatic logic [3:0] pc_fault(input logic [15:0] p, input logic [15:0] psr);
        if (p == EXIT_PC) return ST_EXIT;
        if (p >= 16'h2000 && p <= 16'h7FFF) return ST_UDATA_PC;
        if (p >= 16'hA000) return ST_OSDATA_PC;
        if (p >= 16'h8000 && p <= 16'h9FFF && !psr[15]) return ST_OSCODE_PC;
        return ST_OK;
    endfunction

    function automatic logic [3:0] data_fault(input logic [15:0] a, input logic [15:0] psr);
        if (a <= 16'h1FFF) return ST_UCODE_D;
        if (a >= 16'h8000 && a <= 16'h9FFF) return ST_OSCODE_D;
        if (a >= 16'hA000 && !psr[15]) return ST_OSDATA_D;
        return ST_OK;
    endfunction

    function automatic logic [2:0] nzp_of(input logic [15:0] v);
        if (v == 16'd0) return 3'd2;
        if (v[15]) return 3'd4;
        return 3'd1;
    endfunction

    function automatic logic [2:0] cmp3(input logic lt, input logic eq);
        if (lt) return 3'd4;
        if (eq) return 3'd2;
        return 3'd1;
    endfunction

    assign pc1     = pc_reg + 16'd1;
    assign addr    = rs_reg + ins_reg.imm;
    assign amt     = ins_reg.imm[3:0];
    assign sra_val = 16'($signed(rs_reg) >>> amt);

    // Status for this instruction
    always_comb
    begin
        st = pc_fault(pc_reg, psr_reg);
        if (st == ST_OK && ins_reg.illegal)
        begin
            st = ST_ILLEGAL;
        end
        if (st == ST_OK && ins_reg.is_mem)
        begin
            st = data_fault(addr, psr_reg);
        end
    end

    // Execute datapath (used at the S_MEM/S_OUT transition)
    always_comb
    begin
        npc     = pc1;
        val     = 16'd0;
        wreg    = 1'b1;
        setcc   = 1'b1;
        fromcmp = 1'b0;
        ccv     = 3'd0;
        widx    = ins_reg.dest_reg;
        psr_n   = psr_reg;
        if (ins_reg.cmd <= 6'd7)
        begin
            wreg  = 1'b0;
            setcc = 1'b0;
            if ((psr_reg[2:0] & ins_reg.cmd[2:0]) != 3'd0)
            begin
                npc = pc1 + ins_reg.imm;
            end
        end
        else
        begin
            case (ins_reg.cmd)
                CMD_ADD:     val = rs_reg + rt_reg;
                CMD_MUL:     val = prod_reg[15:0];
                CMD_SUB:     val = rs_reg - rt_reg;
                CMD_DIV:     val = (rt_reg == 16'd0) ? 16'd0 : div_q;
                CMD_ADDI:    val = addr;
                CMD_MOD:     val = (rt_reg == 16'd0) ? 16'd0 : div_r;
                CMD_AND:     val = rs_reg & rt_reg;
                CMD_NOT:     val = ~rs_reg;
                CMD_OR:      val = rs_reg | rt_reg;
                CMD_XOR:     val = rs_reg ^ rt_reg;
                CMD_ANDI:    val = rs_reg & ins_reg.imm;
                CMD_LDR:     val = mrd_reg;
                CMD_STR:
                begin
                    wreg  = 1'b0;
                    setcc = 1'b0;
                end
                CMD_CONST:   val = ins_reg.imm;
                CMD_HICONST: val = {ins_reg.imm[7:0], rd_reg[7:0]};
                CMD_CMP:
                begin
                    fromcmp = 1'b1;
                    ccv = cmp3($signed(rs_reg) < $signed(rt_reg), rs_reg == rt_reg);
                end
                CMD_CMPU:
                begin
                    fromcmp = 1'b1;
                    ccv = cmp3(rs_reg < rt_reg, rs_reg == rt_reg);
                end
                CMD_CMPI:
                begin
                    fromcmp = 1'b1;
                    ccv = cmp3($signed(rs_reg) < $signed(ins_reg.imm), rs_reg == ins_reg.imm);
                end
                CMD_CMPIU:
                begin
                    fromcmp = 1'b1;
                    ccv = cmp3(rs_reg < ins_reg.imm, rs_reg == ins_reg.imm);
                end
                CMD_SLL:     val = rs_reg << amt;
                CMD_SRA:     val = sra_val;
                CMD_SRL:     val = rs_reg >> amt;
                CMD_JSRR:
                begin
                    npc  = rs_reg;
                    val  = pc1;
                    widx = 3'd7;
                end
                CMD_JSR:
                begin
                    // target is imm shifted left by four, with the current PC's top bit ORed into bit 15
                    npc  = {pc_reg[15] | ins_reg.imm[11], ins_reg.imm[10:0], 4'd0};
                    val  = pc1;
                    widx = 3'd7;
                end
                CMD_JMPR:
                begin
                    npc   = rs_reg;
                    wreg  = 1'b0;
                    setcc = 1'b0;
                end
                CMD_JMP:
                begin
                    npc   = pc1 + ins_reg.imm;
                    wreg  = 1'b0;
                    setcc = 1'b0;
                end
                CMD_TRAP:
                begin
                    npc   = 16'h8000 | ins_reg.imm;
                    val   = pc1;
                    widx  = 3'd7;
                    psr_n = 16'h8000;
                end
                default:
                begin
                    npc   = r7_reg;
                    psr_n = psr_reg & 16'h7FFF;
                    wreg  = 1'b0;
                    setcc = 1'b0;
                end
            endcase
            if (fromcmp)
            begin
                wreg = 1'b0;
            end
            if (setcc)
            begin
                psr_n = {psr_n[15], 12'd0, fromcmp ? ccv : nzp_of(val)};
            end
        end
    end

    // Result word for the instruction in the memory step
    always_comb
    begin
        res_next = '0;
        if (ins_reg.is_loadw)
        begin
            res_next.status      = halted_reg ? hcode_reg : ST_OK;
            res_next.next_pc     = pc_reg;
            res_next.psr_value   = psr_reg;
            res_next.mem_written = 1'b1;
            res_next.mem_address = ins_reg.load_address;
            res_next.mem_value   = ins_reg.imm;
        end
        else if (halted_reg)
        begin
            res_next.status    = hcode_reg;
            res_next.next_pc   = pc_reg;
            res_next.psr_value = psr_reg;
        end
        else if (st != ST_OK)
        begin
            res_next.status    = st;
            res_next.next_pc   = pc_reg;
            res_next.psr_value = psr_reg;
            // address only reported for a data access fault
            if (ins_reg.is_mem && pc_fault(pc_reg, psr_reg) == ST_OK)
            begin
                res_next.mem_address = addr;
            end
        end
        else
        begin
            res_next.next_pc   = npc;
            res_next.psr_value = psr_n;
            if (wreg)
            begin
                res_next.reg_written = 1'b1;
                res_next.reg_index   = widx;
                res_next.reg_value   = val;
            end
            if (ins_reg.cmd == CMD_LDR)
            begin
                res_next.mem_address = addr;
                res_next.mem_value   = mrd_reg;
            end
            if (ins_reg.cmd == CMD_STR)
            begin
                res_next.mem_written = 1'b1;
                res_next.mem_address = addr;
                res_next.mem_value   = rt_reg;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_take)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!ins_reg.is_loadw && !halted_reg && st == ST_OK && ins_reg.is_div)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MEM;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                if (mem_go)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control; the clearing pass owns the write port after reset
    always_comb
    begin
        mem_re    = (state_reg == S_EXEC);
        mem_raddr = addr;
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = rt_reg;
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 16'd0;
        end
        else if (mem_go)
        begin
            if (ins_reg.is_loadw)
            begin
                mem_we    = 1'b1;
                mem_waddr = ins_reg.load_address;
                mem_wdata = ins_reg.imm;
            end
            else if (!halted_reg && st == ST_OK && ins_reg.cmd == CMD_STR)
            begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mrd_reg <= mem[mem_raddr];
        end
    end

    // Operand fetch and multiply
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            ins_reg <= q_word;
        end
        if (state_reg == S_READ)
        begin
            rs_reg <= rf_reg[ins_reg.src_reg_s];
            rt_reg <= rf_reg[ins_reg.src_reg_t];
            rd_reg <= rf_reg[ins_reg.dest_reg];
            r7_reg <= rf_reg[7];
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= rs_reg * rt_reg;
        end
    end

    // Architectural state, clearing pass and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 16'h8200;
            psr_reg       <= PSR_RESET;
            halted_reg    <= 1'b0;
            hcode_reg     <= ST_OK;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= 16'd0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 16'd1;
                if (clr_addr_reg == 16'hFFFF)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pc_reg <= cfg_data;
            end
            else if (exec_ok)
            begin
                pc_reg <= npc;
            end
            if (exec_ok)
            begin
                psr_reg <= psr_n;
                if (wreg)
                begin
                    rf_reg[widx] <= val;
                end
            end
            if (exec_fault)
            begin
                halted_reg <= 1'b1;
                hcode_reg  <= st;
            end
            if (mem_go)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule
